// File: hdl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Shared constants and codes for the spectral response resampler.
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int SAMPLE_DEPTH    = 4096;
	localparam int MAX_TAPS        = 64;
	localparam int KERNEL_ROWS_MAX = 8;

	// field widths
	localparam int OP_W     = 2;
	localparam int POS_W    = 12;
	localparam int SEL_W    = 3;
	localparam int VALUE_W  = 24;
	localparam int WL_W     = 32;
	localparam int SAMPLE_W = 24;
	localparam int TAP_W    = 18;
	localparam int SUM_W    = 48;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TCNT_REG_W = 7;
	localparam int ROWS_REG_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_START    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_SCALE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS   = 3'd4;

	localparam logic [OP_W-1:0] OP_LOAD_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_TAP    = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

	// derived sizes
	localparam int KERNEL_DEPTH = (KERNEL_ROWS_MAX + 1) * MAX_TAPS;
	localparam int SA_W   = $clog2(SAMPLE_DEPTH);
	localparam int KA_W   = $clog2(KERNEL_DEPTH);
	localparam int ROW_W  = $clog2(KERNEL_ROWS_MAX + 1);
	localparam int CNT_W  = $clog2(MAX_TAPS + 1);
	localparam int PROD_W = TAP_W + SAMPLE_W;
	localparam int ACC_NEED = PROD_W + $clog2(MAX_TAPS) + 1;
	localparam int ACC_W  = (ACC_NEED > SUM_W + 1) ? ACC_NEED : SUM_W + 1;

	// window start, one guard bit for the borrow of each subtraction
	localparam int DIFF_W = WL_W + 2;

endpackage

// File: hdl/srr_ram.sv
// ----------------------------------------------------------------------------
// srr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module srr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/spectral_response_resampler.sv
// ----------------------------------------------------------------------------
// spectral_response_resampler
// FIR resampling of a stored spectrum onto an output wavelength grid.
// ----------------------------------------------------------------------------
// Load requests (sample or kernel tap) give no result. A compute request steps
// through S_MUL, S_CHK, S_RUN, S_DRAIN and S_DONE before its result is loaded
// into the output register (S_CHK goes straight to S_DONE when the window falls
// outside the sample store, which skips the dot product): the taps are walked
// one per cycle through the single read port of each store, with one multiplier
// feeding the accumulator. The input is stalled while a compute request is in
// progress; a finished result waits in the output register while loads carry on.
// Samples are Q8.15, taps Q1.16 (low 18 bits of value), wavelengths Q16.16,
// and the sum is Q16.31, saturated to 48 bits.
// ----------------------------------------------------------------------------
module spectral_response_resampler (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [srr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srr_pkg::CFG_DATA_W-1:0]      cfg_data,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [srr_pkg::OP_W-1:0]            op,
	input  logic [srr_pkg::POS_W-1:0]           position,
	input  logic [srr_pkg::SEL_W-1:0]           kernel_select,
	input  logic                                derivative,
	input  logic signed [srr_pkg::VALUE_W-1:0]  value,
	input  logic [srr_pkg::WL_W-1:0]            wavelength,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [srr_pkg::SUM_W-1:0]    sum,
	output logic                                out_of_range
);

	import srr_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_CHK   = 3'd2;
	localparam logic [2:0] S_RUN   = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	// configuration registers
	logic [WL_W-1:0]       grid_start_q;
	logic [WL_W-1:0]       index_scale_q;
	logic [WL_W-1:0]       window_offset_q;
	logic [TCNT_REG_W-1:0] tap_count_q;
	logic [ROWS_REG_W-1:0] kernel_rows_q;

	logic [2:0] state_q;

	logic in_acc;
	logic [CNT_W-1:0] taps;
	logic [ROW_W-1:0] rows_m1;
	logic [ROW_W-1:0] use_row;
	logic [ROW_W-1:0] load_row;

	logic           smp_we;
	logic [SA_W-1:0] smp_waddr;
	logic [SA_W-1:0] sa_q;
	logic [SAMPLE_W-1:0] smp_rdata;
	logic           ker_we;
	logic [KA_W-1:0] ker_waddr;
	logic [KA_W-1:0] ka_q;
	logic [TAP_W-1:0] ker_rdata;

	logic signed [DIFF_W-1:0] diff;
	logic [WL_W-1:0]  dmag_q;
	logic             neg_q;
	logic [WL_W-1:0]  idx_q;
	logic [WL_W-1:0]  idx_eff;
	logic             win_oor;
	logic [CNT_W-1:0] cnt_q;
	logic             last_issue;

	logic rd_v_s1, last_s1;
	logic mul_v_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  sat;
	logic oor_q;

	logic                    out_valid_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    out_oor_q;
	logic                    out_load;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// clamp register values to their usable ranges
	always_comb begin
		if (tap_count_q == '0) begin
			taps = CNT_W'(1);
		end else if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
			taps = CNT_W'(MAX_TAPS);
		end else begin
			taps = CNT_W'(tap_count_q);
		end
		if (kernel_rows_q == '0) begin
			rows_m1 = '0;
		end else if (32'(kernel_rows_q) > 32'(KERNEL_ROWS_MAX)) begin
			rows_m1 = ROW_W'(KERNEL_ROWS_MAX - 1);
		end else begin
			rows_m1 = ROW_W'(32'(kernel_rows_q) - 1);
		end
		if (derivative) begin
			use_row  = ROW_W'(KERNEL_ROWS_MAX);
			load_row = ROW_W'(KERNEL_ROWS_MAX);
		end else begin
			use_row  = (32'(kernel_select) > 32'(rows_m1)) ? rows_m1 : ROW_W'(kernel_select);
			load_row = (32'(kernel_select) > 32'(KERNEL_ROWS_MAX - 1)) ?
				ROW_W'(KERNEL_ROWS_MAX - 1) : ROW_W'(kernel_select);
		end
	end

	// store writes happen on the accepting edge
	assign smp_we    = in_acc && (op == OP_LOAD_SAMPLE) && (32'(position) < 32'(SAMPLE_DEPTH));
	assign smp_waddr = SA_W'(position);
	assign ker_we    = in_acc && (op == OP_LOAD_TAP) && (32'(position) < 32'(MAX_TAPS));
	assign ker_waddr = KA_W'(32'(load_row) * MAX_TAPS + 32'(position));

	srr_ram #(.WIDTH(SAMPLE_W), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
		.clk   (clk),
		.we    (smp_we),
		.waddr (smp_waddr),
		.wdata (value),
		.raddr (sa_q),
		.rdata (smp_rdata)
	);

	srr_ram #(.WIDTH(TAP_W), .DEPTH(KERNEL_DEPTH)) u_kernel_ram (
		.clk   (clk),
		.we    (ker_we),
		.waddr (ker_waddr),
		.wdata (value[TAP_W-1:0]),
		.raddr (ka_q),
		.rdata (ker_rdata)
	);

	// window start relative to the grid, no wrap
	assign diff = $signed({2'b00, wavelength}) - $signed({2'b00, window_offset_q})
		- $signed({2'b00, grid_start_q});

	assign idx_eff = neg_q ? '0 : idx_q;
	assign win_oor = (neg_q && (index_scale_q != '0))
		|| ((33'(idx_eff) + 33'(taps)) > 33'(SAMPLE_DEPTH));
	assign last_issue = (cnt_q == taps - CNT_W'(1));

	always_comb begin
		if (acc_q[ACC_W-1:SUM_W-1] == '0 || acc_q[ACC_W-1:SUM_W-1] == '1) begin
			sat = acc_q[SUM_W-1:0];
		end else begin
			sat = acc_q[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_start_q    <= '0;
			index_scale_q   <= WL_W'(65536);
			window_offset_q <= '0;
			tap_count_q     <= TCNT_REG_W'(1);
			kernel_rows_q   <= ROWS_REG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_START:    grid_start_q    <= cfg_data[WL_W-1:0];
				REG_INDEX_SCALE:   index_scale_q   <= cfg_data[WL_W-1:0];
				REG_WINDOW_OFFSET: window_offset_q <= cfg_data[WL_W-1:0];
				REG_TAP_COUNT:     tap_count_q     <= cfg_data[TCNT_REG_W-1:0];
				REG_KERNEL_ROWS:   kernel_rows_q   <= cfg_data[ROWS_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_v_s1     <= 1'b0;
			last_s1     <= 1'b0;
			mul_v_s2    <= 1'b0;
			last_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1  <= (state_q == S_RUN);
			last_s1  <= (state_q == S_RUN) && last_issue;
			mul_v_s2 <= rd_v_s1;
			last_s2  <= last_s1;
			case (state_q)
				S_IDLE: begin
					if (in_acc && op == OP_COMPUTE) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_CHK;
				S_CHK: state_q <= win_oor ? S_DONE : S_RUN;
				S_RUN: begin
					if (last_issue) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (last_s2) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc && op == OP_COMPUTE) begin
			neg_q  <= diff[DIFF_W-1];
			dmag_q <= diff[WL_W-1:0];
			ka_q   <= KA_W'(32'(use_row) * MAX_TAPS);
		end
		if (state_q == S_MUL) begin
			idx_q <= WL_W'(({32'd0, dmag_q} * {32'd0, index_scale_q}) >> 32);
		end
		if (state_q == S_CHK) begin
			sa_q  <= SA_W'(idx_eff);
			cnt_q <= '0;
			acc_q <= '0;
			oor_q <= win_oor;
		end
		if (state_q == S_RUN) begin
			sa_q  <= sa_q + SA_W'(1);
			ka_q  <= ka_q + KA_W'(1);
			cnt_q <= cnt_q + CNT_W'(1);
		end
		prod_s2 <= $signed(ker_rdata) * $signed(smp_rdata);
		if (mul_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (out_load) begin
			sum_q     <= sat;
			out_oor_q <= oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sum          = sum_q;
	assign out_of_range = out_oor_q;

	// the accumulator only sees products while taps are in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_v_s2 |-> (state_q == S_RUN || state_q == S_DRAIN))
		else $error("product arrived outside the tap walk");

	// a new result is only loaded from the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result appeared without a finished request");

	// out-of-window results carry a zero sum
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_range) |-> (sum == '0))
		else $error("out-of-range result with non-zero sum");

	// the tap counter never runs past the tap count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (cnt_q < taps))
		else $error("tap counter overran");

	// a waiting result is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(sum) && $stable(out_of_range))
		else $error("stalled result changed");

endmodule
